/* design/particle_aggregation_step_assert.svh */
// assertion macros for the particle aggregation step block
// used by the top level only, no other dependencies
`ifndef PARTICLE_AGGREGATION_STEP_ASSERT_SVH
`define PARTICLE_AGGREGATION_STEP_ASSERT_SVH

// same-cycle implication
`define PAS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pas assertion failed");

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pas assertion failed");

`endif

/* design/pas_pkg.sv */
// shared types, widths and helpers for the particle aggregation step block
// no dependencies
`default_nettype none

package pas_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = IDX_W + 2;
    localparam int Q_W           = 20;
    localparam int R_W           = 19;
    localparam int NOISE_W       = 7;
    localparam int DIFF_W        = Q_W + 1;
    localparam int SQ_W          = 2 * Q_W + 1;
    localparam int D2_W          = SQ_W + 2;
    localparam int ROOT_W        = (D2_W + 1) / 2;
    localparam int PROD_W        = DIFF_W + 16;
    localparam int SAT_W         = 40;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 19;

    localparam logic [18:0] RST_RANGE    = 19'd9830;
    localparam logic [15:0] RST_FORCE    = 16'd33;
    localparam logic [11:0] RST_BSTEP    = 12'd66;
    localparam logic [15:0] RST_GROW     = 16'd328;
    localparam logic [17:0] RST_BOUND    = 18'd65536;
    localparam logic [15:0] RST_FREE_RAD = 16'd1311;
    localparam logic [15:0] RST_SEED_RAD = 16'd2621;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE    = 3'd0,
        REG_FORCE    = 3'd1,
        REG_BSTEP    = 3'd2,
        REG_GROW     = 3'd3,
        REG_BOUND    = 3'd4,
        REG_FREE_RAD = 3'd5,
        REG_SEED_RAD = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KICK,
        S_MOVE,
        S_SCAN,
        S_RANGE,
        S_RAD,
        S_ATT,
        S_SQRT,
        S_MUL,
        S_DGO,
        S_DIV,
        S_ACC,
        S_FIN
    } state_t;

    // clamp a wide signed value to the q4.16 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((1 <<< (Q_W - 1)) - 1);
        lo = -SAT_W'(1 <<< (Q_W - 1));
        if (v > hi)
            return hi[Q_W-1:0];
        else if (v < lo)
            return lo[Q_W-1:0];
        else
            return v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/pas_mem.sv */
// particle table storage: position, velocity and radius arrays
// one write port, one registered read port; uses pas_pkg
`default_nettype none

module pas_mem (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [pas_pkg::IDX_W-1:0]     wr_addr,
    input  wire logic [3*pas_pkg::Q_W-1:0]     wr_pos,
    input  wire logic [3*pas_pkg::Q_W-1:0]     wr_vel,
    input  wire logic [pas_pkg::R_W-1:0]       wr_rad,
    input  wire logic [pas_pkg::IDX_W-1:0]     rd_addr,
    output logic      [3*pas_pkg::Q_W-1:0]     rd_pos,
    output logic      [3*pas_pkg::Q_W-1:0]     rd_vel,
    output logic      [pas_pkg::R_W-1:0]       rd_rad
);

    logic [3*pas_pkg::Q_W-1:0] pos_mem [pas_pkg::MAX_PARTICLES];
    logic [3*pas_pkg::Q_W-1:0] vel_mem [pas_pkg::MAX_PARTICLES];
    logic [pas_pkg::R_W-1:0]   rad_mem [pas_pkg::MAX_PARTICLES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= wr_pos;
            vel_mem[wr_addr] <= wr_vel;
            rad_mem[wr_addr] <= wr_rad;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos <= pos_mem[rd_addr];
        rd_vel <= vel_mem[rd_addr];
        rd_rad <= rad_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/pas_sqrt.sv */
// iterative floor square root, two radicand bits per cycle
// uses pas_pkg widths
`default_nettype none

module pas_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pas_pkg::D2_W-1:0]       radicand,
    output logic                                done,
    output logic      [pas_pkg::ROOT_W-1:0]     root
);

    localparam int RAD_W = 2 * pas_pkg::ROOT_W;
    localparam int REM_W = pas_pkg::ROOT_W + 4;
    localparam int CNT_W = $clog2(pas_pkg::ROOT_W);

    logic                        run_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [RAD_W-1:0]            rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [pas_pkg::ROOT_W-1:0]  root_reg;

    logic [REM_W-1:0]            rem_shift;
    logic [REM_W-1:0]            trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(pas_pkg::ROOT_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[pas_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[pas_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* design/pas_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// uses pas_pkg widths
`default_nettype none

module pas_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pas_pkg::PROD_W-1:0]     dividend,
    input  wire logic [pas_pkg::ROOT_W-1:0]     divisor,
    output logic                                done,
    output logic      [pas_pkg::PROD_W-1:0]     quotient
);

    localparam int REM_W = pas_pkg::ROOT_W + 1;
    localparam int CNT_W = $clog2(pas_pkg::PROD_W);

    logic                         run_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [pas_pkg::PROD_W-1:0]   nq_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [pas_pkg::ROOT_W-1:0]   den_reg;

    logic [REM_W-1:0]             rem_shift;
    logic                         fits;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], nq_reg[pas_pkg::PROD_W-1]};
        fits      = rem_shift >= REM_W'(den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(pas_pkg::PROD_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            nq_reg  <= {nq_reg[pas_pkg::PROD_W-2:0], fits};
            rem_reg <= fits ? rem_shift - REM_W'(den_reg) : rem_shift;
        end
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

`default_nettype wire

/* design/particle_aggregation_step.sv */
// top level of the particle aggregation step block: sequencer, scan and datapath
// uses pas_pkg, pas_mem, pas_sqrt, pas_div and the assertion macro header
//
// usage
//   command channel: an item is taken at a rising edge with start high and busy low.
//   a load (command 0) writes one table entry and its word comes out on the next
//   cycle; busy stays low, so loads may be issued every cycle.
//   a step (command 1) of an unloaded entry returns an all-zero word on the next
//   cycle, also without raising busy. a step of an attached entry returns the
//   stored entry from the kick state. a step of a free particle runs the
//   256-entry nearest search, which reads one table entry per cycle through the
//   single read port and then drains its pipeline; when an attached particle is
//   in range the square root follows and, unless the root is zero, the shared
//   divider for each of the three axes.
//   each result word stands on the out_* ports for exactly one cycle while
//   result_valid is high; the receiver has no way to stall it.
//   configuration: cfg_valid/cfg_ready with a register index and data; cfg_ready
//   is always high, writes belong to idle periods, unknown indexes are dropped.
//   reset: asynchronous, active low; clears the sequencer, the loaded and
//   attached flags and loads the register defaults; table contents stay as they
//   are and are never used before written.
`default_nettype none

module particle_aggregation_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              command,
    input  wire logic        [7:0]                 particle_index,
    input  wire logic signed [19:0]                load_x,
    input  wire logic signed [19:0]                load_y,
    input  wire logic signed [19:0]                load_z,
    input  wire logic signed [19:0]                load_vx,
    input  wire logic signed [19:0]                load_vy,
    input  wire logic signed [19:0]                load_vz,
    input  wire logic                              load_attached,
    input  wire logic signed [6:0]                 noise_x,
    input  wire logic signed [6:0]                 noise_y,
    input  wire logic signed [6:0]                 noise_z,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pas_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   result_valid,
    output logic        [7:0]                      out_index,
    output logic signed [19:0]                     out_x,
    output logic signed [19:0]                     out_y,
    output logic signed [19:0]                     out_z,
    output logic signed [19:0]                     out_vx,
    output logic signed [19:0]                     out_vy,
    output logic signed [19:0]                     out_vz,
    output logic        [18:0]                     out_radius,
    output logic                                   out_attached,
    output logic                                   newly_attached
);

    localparam int QW = pas_pkg::Q_W;

    // sequencer
    pas_pkg::state_t state_reg;
    pas_pkg::state_t state_next;

    // configuration registers
    logic [18:0] rng_reg;
    logic [15:0] force_reg;
    logic [11:0] bstep_reg;
    logic [15:0] grow_reg;
    logic [17:0] bnd_reg;
    logic [15:0] frad_reg;
    logic [15:0] srad_reg;

    // per-entry flags, cleared by reset
    logic [pas_pkg::MAX_PARTICLES-1:0] valid_flag_reg;
    logic [pas_pkg::MAX_PARTICLES-1:0] att_flag_reg;

    // particle being stepped
    logic [pas_pkg::IDX_W-1:0]       k_reg;
    logic signed [QW-1:0]            pos_reg [3];
    logic signed [QW-1:0]            vel_reg [3];
    logic [pas_pkg::R_W-1:0]         rad_reg;
    logic signed [pas_pkg::NOISE_W-1:0] noise_reg [3];

    // nearest search pipeline
    logic [pas_pkg::CNT_W-1:0]       scan_cnt_reg;
    logic                            p1_ok_reg;
    logic [pas_pkg::IDX_W-1:0]       p1_idx_reg;
    logic                            p2_ok_reg;
    logic [pas_pkg::IDX_W-1:0]       p2_idx_reg;
    logic signed [pas_pkg::DIFF_W-1:0] diff2_reg [3];
    logic                            p3_ok_reg;
    logic [pas_pkg::IDX_W-1:0]       p3_idx_reg;
    logic signed [pas_pkg::DIFF_W-1:0] diff3_reg [3];
    logic [pas_pkg::SQ_W-1:0]        sq3_reg [3];
    logic                            found_reg;
    logic [pas_pkg::IDX_W-1:0]       best_idx_reg;
    logic [pas_pkg::D2_W-1:0]        best_d2_reg;
    logic signed [pas_pkg::DIFF_W-1:0] best_diff_reg [3];

    // pull and attach
    logic [37:0]                     rng_sq_reg;
    logic [39:0]                     s_sq_reg;
    logic                            att_reg;
    logic [1:0]                      axis_reg;
    logic [pas_pkg::PROD_W-1:0]      prod_reg;
    logic                            neg_reg;

    // result word
    logic                            result_valid_reg;
    logic [7:0]                      out_index_reg;
    logic signed [QW-1:0]            out_pos_reg [3];
    logic signed [QW-1:0]            out_vel_reg [3];
    logic [pas_pkg::R_W-1:0]         out_rad_reg;
    logic                            out_att_reg;
    logic                            out_newly_reg;

    // memory and unit hookup
    logic                            mem_wr_en;
    logic [pas_pkg::IDX_W-1:0]       mem_wr_addr;
    logic [3*QW-1:0]                 mem_wr_pos;
    logic [3*QW-1:0]                 mem_wr_vel;
    logic [pas_pkg::R_W-1:0]         mem_wr_rad;
    logic [pas_pkg::IDX_W-1:0]       mem_rd_addr;
    logic [3*QW-1:0]                 mem_rd_pos;
    logic [3*QW-1:0]                 mem_rd_vel;
    logic [pas_pkg::R_W-1:0]         mem_rd_rad;
    logic                            sqrt_start;
    logic                            sqrt_done;
    logic [pas_pkg::ROOT_W-1:0]      sqrt_root;
    logic                            div_start;
    logic                            div_done;
    logic [pas_pkg::PROD_W-1:0]      div_quot;

    // combinational datapath values
    logic                            accept;
    logic                            is_load;
    logic [pas_pkg::IDX_W-1:0]       in_addr;
    logic signed [QW-1:0]            kick_vel [3];
    logic signed [QW-1:0]            move_pos [3];
    logic signed [QW-1:0]            move_vel [3];
    logic signed [pas_pkg::DIFF_W-1:0] scan_diff [3];
    logic [pas_pkg::D2_W-1:0]        scan_d2;
    logic                            in_range;
    logic [pas_pkg::R_W:0]           rad_sum;
    logic [49:0]                     att_lhs;
    logic [49:0]                     att_rhs;
    logic signed [pas_pkg::DIFF_W-1:0] pull_diff;
    logic [pas_pkg::DIFF_W-1:0]      pull_mag;
    logic signed [38:0]              pull_sum;
    logic signed [QW-1:0]            fin_vel [3];
    logic [pas_pkg::R_W:0]           grow_sum;
    logic [pas_pkg::R_W-1:0]         fin_rad;
    logic [pas_pkg::R_W-1:0]         load_rad;
    logic                            scan_last;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign is_load   = (command == pas_pkg::CMD_LOAD);
    assign in_addr   = pas_pkg::IDX_W'(particle_index);
    assign scan_last = (scan_cnt_reg == pas_pkg::CNT_W'(pas_pkg::MAX_PARTICLES + 2));
    assign load_rad  = load_attached ? pas_pkg::R_W'(srad_reg) : pas_pkg::R_W'(frad_reg);

    pas_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_pos  (mem_wr_pos),
        .wr_vel  (mem_wr_vel),
        .wr_rad  (mem_wr_rad),
        .rd_addr (mem_rd_addr),
        .rd_pos  (mem_rd_pos),
        .rd_vel  (mem_rd_vel),
        .rd_rad  (mem_rd_rad)
    );

    pas_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (best_d2_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (sqrt_root),
        .done     (div_done),
        .quotient (div_quot)
    );

    // brownian kick, bounce and the nearest search difference
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [QW:0]            kv;
            logic signed [QW:0]            ps;
            logic signed [QW:0]            bnd_s;
            logic signed [QW:0]            nv;
            logic signed [pas_pkg::NOISE_W+12:0] kp;
            logic signed [QW-1:0]          p;
            logic signed [QW-1:0]          v;
            kp    = noise_reg[a] * $signed({1'b0, bstep_reg});
            kv    = (QW+1)'($signed(mem_rd_vel[a*QW +: QW])) + (QW+1)'(kp);
            kick_vel[a] = pas_pkg::sat_q(pas_pkg::SAT_W'(kv));
            ps    = (QW+1)'(pos_reg[a]) + (QW+1)'(vel_reg[a]);
            p     = pas_pkg::sat_q(pas_pkg::SAT_W'(ps));
            v     = vel_reg[a];
            bnd_s = $signed({3'b000, bnd_reg});
            nv    = -((QW+1)'(v));
            if ((QW+1)'(p) < -bnd_s)
            begin
                p = QW'(-bnd_s);
                v = QW'(nv >>> 1);
            end
            else if ((QW+1)'(p) > bnd_s)
            begin
                p = QW'(bnd_s);
                v = QW'(nv >>> 1);
            end
            move_pos[a]  = p;
            move_vel[a]  = v;
            scan_diff[a] = (QW+1)'($signed(mem_rd_pos[a*QW +: QW])) - (QW+1)'(pos_reg[a]);
        end
        scan_d2 = pas_pkg::D2_W'(sq3_reg[0]) + pas_pkg::D2_W'(sq3_reg[1])
                + pas_pkg::D2_W'(sq3_reg[2]);
    end

    // range, attach and pull arithmetic, plus the final radius and velocity
    always_comb
    begin
        in_range  = pas_pkg::D2_W'(rng_sq_reg) > best_d2_reg;
        rad_sum   = (pas_pkg::R_W+1)'(mem_rd_rad) + (pas_pkg::R_W+1)'(rad_reg);
        att_lhs   = (50'(best_d2_reg) << 6) + (50'(best_d2_reg) << 5)
                  + (50'(best_d2_reg) << 2);
        att_rhs   = (50'(s_sq_reg) << 6) + (50'(s_sq_reg) << 4) + 50'(s_sq_reg);
        pull_diff = best_diff_reg[axis_reg];
        pull_mag  = pull_diff[pas_pkg::DIFF_W-1] ? pas_pkg::DIFF_W'(-pull_diff)
                                                 : pas_pkg::DIFF_W'(pull_diff);
        pull_sum  = 39'(vel_reg[axis_reg])
                  + (neg_reg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot}));
        grow_sum  = (pas_pkg::R_W+1)'(rad_reg) + (pas_pkg::R_W+1)'(grow_reg);
        fin_rad   = att_reg ? (grow_sum[pas_pkg::R_W] ? '1 : grow_sum[pas_pkg::R_W-1:0])
                            : rad_reg;
        for (int a = 0; a < 3; a++)
        begin
            fin_vel[a] = att_reg ? '0 : vel_reg[a];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pas_pkg::S_IDLE:
            begin
                if (start && !is_load && valid_flag_reg[in_addr])
                    state_next = pas_pkg::S_KICK;
            end
            pas_pkg::S_KICK:
                state_next = att_flag_reg[k_reg] ? pas_pkg::S_IDLE : pas_pkg::S_MOVE;
            pas_pkg::S_MOVE:
                state_next = pas_pkg::S_SCAN;
            pas_pkg::S_SCAN:
            begin
                if (scan_last)
                    state_next = pas_pkg::S_RANGE;
            end
            pas_pkg::S_RANGE:
                state_next = found_reg ? pas_pkg::S_RAD : pas_pkg::S_FIN;
            pas_pkg::S_RAD:
                state_next = in_range ? pas_pkg::S_ATT : pas_pkg::S_FIN;
            pas_pkg::S_ATT:
                state_next = pas_pkg::S_SQRT;
            pas_pkg::S_SQRT:
            begin
                if (sqrt_done)
                    state_next = (sqrt_root == '0) ? pas_pkg::S_FIN : pas_pkg::S_MUL;
            end
            pas_pkg::S_MUL:
                state_next = pas_pkg::S_DGO;
            pas_pkg::S_DGO:
                state_next = pas_pkg::S_DIV;
            pas_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = pas_pkg::S_ACC;
            end
            pas_pkg::S_ACC:
                state_next = (axis_reg == 2'd2) ? pas_pkg::S_FIN : pas_pkg::S_MUL;
            pas_pkg::S_FIN:
                state_next = pas_pkg::S_IDLE;
            default:
                state_next = pas_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy        = (state_reg != pas_pkg::S_IDLE);
        sqrt_start  = (state_reg == pas_pkg::S_ATT);
        div_start   = (state_reg == pas_pkg::S_DGO);
        mem_wr_en   = 1'b0;
        mem_wr_addr = k_reg;
        mem_wr_pos  = {pos_reg[2], pos_reg[1], pos_reg[0]};
        mem_wr_vel  = {fin_vel[2], fin_vel[1], fin_vel[0]};
        mem_wr_rad  = fin_rad;
        case (state_reg)
            pas_pkg::S_IDLE:  mem_rd_addr = in_addr;
            pas_pkg::S_SCAN:  mem_rd_addr = scan_cnt_reg[pas_pkg::IDX_W-1:0];
            pas_pkg::S_RANGE: mem_rd_addr = best_idx_reg;
            default:          mem_rd_addr = k_reg;
        endcase
        if (state_reg == pas_pkg::S_IDLE && start && is_load)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = in_addr;
            mem_wr_pos  = {load_z, load_y, load_x};
            mem_wr_vel  = {load_vz, load_vy, load_vx};
            mem_wr_rad  = load_rad;
        end
        else if (state_reg == pas_pkg::S_FIN)
        begin
            mem_wr_en = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pas_pkg::S_IDLE;
            rng_reg          <= pas_pkg::RST_RANGE;
            force_reg        <= pas_pkg::RST_FORCE;
            bstep_reg        <= pas_pkg::RST_BSTEP;
            grow_reg         <= pas_pkg::RST_GROW;
            bnd_reg          <= pas_pkg::RST_BOUND;
            frad_reg         <= pas_pkg::RST_FREE_RAD;
            srad_reg         <= pas_pkg::RST_SEED_RAD;
            valid_flag_reg   <= '0;
            att_flag_reg     <= '0;
            result_valid_reg <= 1'b0;
            scan_cnt_reg     <= '0;
            p1_ok_reg        <= 1'b0;
            p2_ok_reg        <= 1'b0;
            p3_ok_reg        <= 1'b0;
            found_reg        <= 1'b0;
            att_reg          <= 1'b0;
            axis_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pas_pkg::REG_RANGE:    rng_reg   <= cfg_data[18:0];
                    pas_pkg::REG_FORCE:    force_reg <= cfg_data[15:0];
                    pas_pkg::REG_BSTEP:    bstep_reg <= cfg_data[11:0];
                    pas_pkg::REG_GROW:     grow_reg  <= cfg_data[15:0];
                    pas_pkg::REG_BOUND:    bnd_reg   <= cfg_data[17:0];
                    pas_pkg::REG_FREE_RAD: frad_reg  <= cfg_data[15:0];
                    pas_pkg::REG_SEED_RAD: srad_reg  <= cfg_data[15:0];
                    default:               ;
                endcase
            end

            case (state_reg)
                pas_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        if (is_load)
                        begin
                            valid_flag_reg[in_addr] <= 1'b1;
                            att_flag_reg[in_addr]   <= load_attached;
                            result_valid_reg        <= 1'b1;
                        end
                        else if (!valid_flag_reg[in_addr])
                        begin
                            result_valid_reg <= 1'b1;
                        end
                    end
                end
                pas_pkg::S_KICK:
                begin
                    if (att_flag_reg[k_reg])
                        result_valid_reg <= 1'b1;
                end
                pas_pkg::S_MOVE:
                begin
                    scan_cnt_reg <= '0;
                    found_reg    <= 1'b0;
                    att_reg      <= 1'b0;
                end
                pas_pkg::S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    p1_ok_reg    <= (scan_cnt_reg < pas_pkg::CNT_W'(pas_pkg::MAX_PARTICLES))
                                 && valid_flag_reg[scan_cnt_reg[pas_pkg::IDX_W-1:0]]
                                 && att_flag_reg[scan_cnt_reg[pas_pkg::IDX_W-1:0]];
                    p2_ok_reg    <= p1_ok_reg;
                    p3_ok_reg    <= p2_ok_reg;
                    if (p3_ok_reg && (!found_reg || scan_d2 < best_d2_reg))
                        found_reg <= 1'b1;
                end
                pas_pkg::S_ATT:
                    att_reg <= att_lhs < att_rhs;
                pas_pkg::S_SQRT:
                    axis_reg <= '0;
                pas_pkg::S_ACC:
                    axis_reg <= axis_reg + 1'b1;
                pas_pkg::S_FIN:
                begin
                    att_flag_reg[k_reg] <= att_reg;
                    result_valid_reg    <= 1'b1;
                end
                default:
                    ;
            endcase
        end
    end

    // datapath and result word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pas_pkg::S_IDLE:
            begin
                k_reg        <= in_addr;
                noise_reg[0] <= noise_x;
                noise_reg[1] <= noise_y;
                noise_reg[2] <= noise_z;
                out_index_reg <= particle_index;
                out_newly_reg <= 1'b0;
                if (is_load)
                begin
                    out_pos_reg[0] <= load_x;
                    out_pos_reg[1] <= load_y;
                    out_pos_reg[2] <= load_z;
                    out_vel_reg[0] <= load_vx;
                    out_vel_reg[1] <= load_vy;
                    out_vel_reg[2] <= load_vz;
                    out_rad_reg    <= load_rad;
                    out_att_reg    <= load_attached;
                end
                else
                begin
                    // unloaded entry reads as all zero
                    for (int a = 0; a < 3; a++)
                    begin
                        out_pos_reg[a] <= '0;
                        out_vel_reg[a] <= '0;
                    end
                    out_rad_reg <= '0;
                    out_att_reg <= 1'b0;
                end
            end
            pas_pkg::S_KICK:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pos_reg[a]     <= $signed(mem_rd_pos[a*QW +: QW]);
                    vel_reg[a]     <= kick_vel[a];
                    out_pos_reg[a] <= $signed(mem_rd_pos[a*QW +: QW]);
                    out_vel_reg[a] <= $signed(mem_rd_vel[a*QW +: QW]);
                end
                rad_reg     <= mem_rd_rad;
                out_rad_reg <= mem_rd_rad;
                out_att_reg <= 1'b1;
            end
            pas_pkg::S_MOVE:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pos_reg[a] <= move_pos[a];
                    vel_reg[a] <= move_vel[a];
                end
            end
            pas_pkg::S_SCAN:
            begin
                p1_idx_reg <= scan_cnt_reg[pas_pkg::IDX_W-1:0];
                p2_idx_reg <= p1_idx_reg;
                p3_idx_reg <= p2_idx_reg;
                for (int a = 0; a < 3; a++)
                begin
                    diff2_reg[a] <= scan_diff[a];
                    diff3_reg[a] <= diff2_reg[a];
                    sq3_reg[a]   <= pas_pkg::SQ_W'(diff2_reg[a] * diff2_reg[a]);
                end
                if (p3_ok_reg && (!found_reg || scan_d2 < best_d2_reg))
                begin
                    best_idx_reg <= p3_idx_reg;
                    best_d2_reg  <= scan_d2;
                    for (int a = 0; a < 3; a++)
                        best_diff_reg[a] <= diff3_reg[a];
                end
            end
            pas_pkg::S_RANGE:
                rng_sq_reg <= rng_reg * rng_reg;
            pas_pkg::S_RAD:
                s_sq_reg <= rad_sum * rad_sum;
            pas_pkg::S_MUL:
            begin
                prod_reg <= pas_pkg::PROD_W'(pull_mag) * pas_pkg::PROD_W'(force_reg);
                neg_reg  <= pull_diff[pas_pkg::DIFF_W-1];
            end
            pas_pkg::S_ACC:
                vel_reg[axis_reg] <= pas_pkg::sat_q(pas_pkg::SAT_W'(pull_sum));
            pas_pkg::S_FIN:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    out_pos_reg[a] <= pos_reg[a];
                    out_vel_reg[a] <= fin_vel[a];
                end
                out_rad_reg   <= fin_rad;
                out_att_reg   <= att_reg;
                out_newly_reg <= att_reg;
            end
            default:
                ;
        endcase
    end

    assign result_valid   = result_valid_reg;
    assign out_index      = out_index_reg;
    assign out_x          = out_pos_reg[0];
    assign out_y          = out_pos_reg[1];
    assign out_z          = out_pos_reg[2];
    assign out_vx         = out_vel_reg[0];
    assign out_vy         = out_vel_reg[1];
    assign out_vz         = out_vel_reg[2];
    assign out_radius     = out_rad_reg;
    assign out_attached   = out_att_reg;
    assign newly_attached = out_newly_reg;

`include "particle_aggregation_step_assert.svh"

    // every accepted word either starts a step or answers on the next cycle
    `PAS_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || result_valid)
    // a result always marks the end of the work on its word
    `PAS_ASSERT_IMPL(a_result_idle, clk, rst_n, result_valid, !busy)
    // an attaching particle comes to rest
    `PAS_ASSERT_IMPL(a_newly_stops, clk, rst_n, result_valid && newly_attached, out_attached && out_vx == '0 && out_vy == '0 && out_vz == '0)
    // range check only follows a complete scan
    `PAS_ASSERT_IMPL(a_scan_done, clk, rst_n, state_reg == pas_pkg::S_RANGE, $past(state_reg) == pas_pkg::S_SCAN)

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the particle aggregation step block
// depends on pas_pkg and the particle_aggregation_step top level
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import pas_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register behind it

    // one command word as the sender queues it
    typedef struct packed {
        cmd_t            command;
        logic [7:0]      idx;
        logic [2:0][19:0] lp;
        logic [2:0][19:0] lv;
        logic            attach;
        logic [2:0][6:0] noise;
    } cmd_item_t;

    // one result word: the entry as it stands after the command
    typedef struct packed {
        logic [7:0]       idx;
        logic [2:0][19:0] p;
        logic [2:0][19:0] v;
        logic [18:0]      radius;
        logic             attached;
        logic             newly;
    } particle_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic command;
    logic [7:0] particle_index;
    logic signed [19:0] load_x, load_y, load_z, load_vx, load_vy, load_vz;
    logic load_attached;
    logic signed [6:0] noise_x, noise_y, noise_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic result_valid;
    logic [7:0] out_index;
    logic signed [19:0] out_x, out_y, out_z, out_vx, out_vy, out_vz;
    logic [18:0] out_radius;
    logic out_attached;
    logic newly_attached;

    particle_aggregation_step dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .particle_index (particle_index),
        .load_x         (load_x),
        .load_y         (load_y),
        .load_z         (load_z),
        .load_vx        (load_vx),
        .load_vy        (load_vy),
        .load_vz        (load_vz),
        .load_attached  (load_attached),
        .noise_x        (noise_x),
        .noise_y        (noise_y),
        .noise_z        (noise_z),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .out_index      (out_index),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_vx         (out_vx),
        .out_vy         (out_vy),
        .out_vz         (out_vz),
        .out_radius     (out_radius),
        .out_attached   (out_attached),
        .newly_attached (newly_attached)
    );

    // ------------------------------------------------------------------
    // clock and bookkeeping
    // ------------------------------------------------------------------
    always #1 clk = ~clk;

    cmd_item_t      pending_cmds[$];     // filled by the stimulus block
    particle_word_t expected_words[$];   // predicted, waiting for the block
    cmd_item_t      cur_cmd;
    int             sender_idle_pct;
    int             error_count;
    int             quiet_cycles;

    // predictor copy of the register file
    logic [18:0] cfg_range;
    logic [15:0] cfg_force;
    logic [11:0] cfg_bstep;
    logic [15:0] cfg_grow;
    logic [17:0] cfg_bound;
    logic [15:0] cfg_free_rad;
    logic [15:0] cfg_seed_rad;

    // predictor copy of the particle store
    logic [2:0][19:0] pos_s [MAX_PARTICLES];
    logic [2:0][19:0] vel_s [MAX_PARTICLES];
    logic [18:0]      rad_s [MAX_PARTICLES];
    logic             attached_s [MAX_PARTICLES];
    logic             loaded_s [MAX_PARTICLES];

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_q(input longint x);
        if (x > 524287)
            return 524287;
        if (x < -524288)
            return -524288;
        return x;
    endfunction

    // largest r with r*r <= x, bit by bit from the top
    function automatic longint root_floor(input longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic particle_word_t entry_word(input int k, input logic newly);
        particle_word_t w;
        w.idx      = 8'(k);
        w.p        = pos_s[k];
        w.v        = vel_s[k];
        w.radius   = rad_s[k];
        w.attached = attached_s[k];
        w.newly    = newly;
        return w;
    endfunction

    // applies one accepted command to the store copy, returns the word it yields
    function automatic particle_word_t apply_command(input cmd_item_t it);
        particle_word_t w;
        int     k;
        int     best;
        longint v, p, n, bnd, d, d2, best_d2, rng, len, s, r, pj, pk;
        k = it.idx;
        w = '0;
        w.idx = it.idx;
        if (it.command == CMD_LOAD)
        begin
            pos_s[k]      = it.lp;
            vel_s[k]      = it.lv;
            attached_s[k] = it.attach;
            rad_s[k]      = it.attach ? 19'(cfg_seed_rad) : 19'(cfg_free_rad);
            loaded_s[k]   = 1'b1;
            return entry_word(k, 1'b0);
        end
        // never loaded: all-zero word
        if (!loaded_s[k])
            return w;
        // already stuck: reported unchanged
        if (attached_s[k])
            return entry_word(k, 1'b0);

        // brownian kick, move, wall bounce
        bnd = longint'(cfg_bound);
        for (int a = 0; a < 3; a++)
        begin
            v = $signed(vel_s[k][a]);
            n = $signed(it.noise[a]);
            p = $signed(pos_s[k][a]);
            v = clamp_q(v + n * longint'(cfg_bstep));
            p = clamp_q(p + v);
            if (p < -bnd)
            begin
                p = -bnd;
                v = (-v) >>> 1;
            end
            if (p > bnd)
            begin
                p = bnd;
                v = (-v) >>> 1;
            end
            pos_s[k][a] = 20'(p);
            vel_s[k][a] = 20'(v);
        end

        // nearest attached entry, lowest index on a tie
        best = -1;
        best_d2 = 0;
        for (int j = 0; j < MAX_PARTICLES; j++)
        begin
            if (loaded_s[j] && attached_s[j])
            begin
                d2 = 0;
                for (int a = 0; a < 3; a++)
                begin
                    pj = $signed(pos_s[j][a]);
                    pk = $signed(pos_s[k][a]);
                    d2 += (pj - pk) * (pj - pk);
                end
                if (best < 0 || d2 < best_d2)
                begin
                    best = j;
                    best_d2 = d2;
                end
            end
        end

        if (best >= 0)
        begin
            rng = longint'(cfg_range);
            if (best_d2 < rng * rng)
            begin
                len = root_floor(best_d2);
                // zero distance: no direction, no pull
                if (len > 0)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        pj = $signed(pos_s[best][a]);
                        pk = $signed(pos_s[k][a]);
                        d = (pj - pk) * longint'(cfg_force) / len;
                        v = $signed(vel_s[k][a]);
                        vel_s[k][a] = 20'(clamp_q(v + d));
                    end
                end
                s = longint'(rad_s[best]) + longint'(rad_s[k]);
                if (100 * best_d2 < 81 * s * s)
                begin
                    r = longint'(rad_s[k]) + longint'(cfg_grow);
                    attached_s[k] = 1'b1;
                    rad_s[k] = (r > 524287) ? 19'h7FFFF : 19'(r);
                    vel_s[k] = '0;
                    return entry_word(k, 1'b1);
                end
            end
        end
        return entry_word(k, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // register copy follows every accepted configuration write
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_range    <= RST_RANGE;
            cfg_force    <= RST_FORCE;
            cfg_bstep    <= RST_BSTEP;
            cfg_grow     <= RST_GROW;
            cfg_bound    <= RST_BOUND;
            cfg_free_rad <= RST_FREE_RAD;
            cfg_seed_rad <= RST_SEED_RAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RANGE:    cfg_range    <= cfg_data[18:0];
                REG_FORCE:    cfg_force    <= cfg_data[15:0];
                REG_BSTEP:    cfg_bstep    <= cfg_data[11:0];
                REG_GROW:     cfg_grow     <= cfg_data[15:0];
                REG_BOUND:    cfg_bound    <= cfg_data[17:0];
                REG_FREE_RAD: cfg_free_rad <= cfg_data[15:0];
                REG_SEED_RAD: cfg_seed_rad <= cfg_data[15:0];
                default:      ;  // unknown index is dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // driver: may take the next queued command whenever the slot is free
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a command word is taken at this edge
            if (start && !busy)
                expected_words.push_back(apply_command(cur_cmd));
            // slot free: either stay idle or present the next word
            if (!start || !busy)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    command        <= cur_cmd.command;
                    particle_index <= cur_cmd.idx;
                    load_x         <= cur_cmd.lp[0];
                    load_y         <= cur_cmd.lp[1];
                    load_z         <= cur_cmd.lp[2];
                    load_vx        <= cur_cmd.lv[0];
                    load_vy        <= cur_cmd.lv[1];
                    load_vz        <= cur_cmd.lv[2];
                    load_attached  <= cur_cmd.attach;
                    noise_x        <= cur_cmd.noise[0];
                    noise_y        <= cur_cmd.noise[1];
                    noise_z        <= cur_cmd.noise[2];
                    start          <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed word is matched against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [19:0] exp_v,
                                        input logic [19:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        particle_word_t w;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word for index %0d", $time, out_index);
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                check_field("out_index", 20'(w.idx), 20'(out_index));
                check_field("out_x", w.p[0], out_x);
                check_field("out_y", w.p[1], out_y);
                check_field("out_z", w.p[2], out_z);
                check_field("out_vx", w.v[0], out_vx);
                check_field("out_vy", w.v[1], out_vy);
                check_field("out_vz", w.v[2], out_vz);
                check_field("out_radius", 20'(w.radius), 20'(out_radius));
                check_field("out_attached", 20'(w.attached), 20'(out_attached));
                check_field("newly_attached", 20'(w.newly), 20'(newly_attached));
            end
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[particle_aggregation_step] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_item_t make_load(input int k, input int x, input int y,
                                            input int z, input int vx, input int vy,
                                            input int vz, input logic seed);
        cmd_item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.idx     = 8'(k);
        it.lp      = {20'(z), 20'(y), 20'(x)};
        it.lv      = {20'(vz), 20'(vy), 20'(vx)};
        it.attach  = seed;
        return it;
    endfunction

    function automatic cmd_item_t make_step(input int k, input int nx, input int ny,
                                            input int nz);
        cmd_item_t it;
        it = '0;
        it.command = CMD_STEP;
        it.idx     = 8'(k);
        it.noise   = {7'(nz), 7'(ny), 7'(nx)};
        return it;
    endfunction

    function automatic int rand_noise();
        return int'($urandom_range(0, 99)) - 50;
    endfunction

    // fully random word: any command, index, position, velocity and attach flag; noise as for steps
    function automatic cmd_item_t random_cmd();
        cmd_item_t it;
        it.command = cmd_t'($urandom_range(0, 1));
        it.idx     = 8'($urandom);
        for (int a = 0; a < 3; a++)
        begin
            it.lp[a]    = 20'($urandom);
            it.lv[a]    = 20'($urandom);
            it.noise[a] = 7'(rand_noise());
        end
        it.attach = 1'($urandom);
        return it;
    endfunction

    // a seed with a free particle nearby, then a run of steps on the free one
    task automatic queue_cluster();
        int seed_k, free_k, spread, nsteps;
        int sp[3];
        int fp[3];
        seed_k = $urandom_range(0, 255);
        free_k = $urandom_range(0, 255);
        if (free_k == seed_k)
            free_k = (seed_k + 1) % 256;
        spread = ($urandom_range(0, 1) == 1) ? 2500 : 14000;
        for (int a = 0; a < 3; a++)
        begin
            sp[a] = int'($urandom_range(0, 120000)) - 60000;
            fp[a] = sp[a] + int'($urandom_range(0, 2 * spread)) - spread;
        end
        pending_cmds.push_back(make_load(seed_k, sp[0], sp[1], sp[2],
                                         0, 0, 0, 1'b1));
        pending_cmds.push_back(make_load(free_k, fp[0], fp[1], fp[2],
                                         int'($urandom_range(0, 1000)) - 500,
                                         int'($urandom_range(0, 1000)) - 500,
                                         int'($urandom_range(0, 1000)) - 500, 1'b0));
        nsteps = $urandom_range(3, 8);
        for (int i = 0; i < nsteps; i++)
            pending_cmds.push_back(make_step(free_k, rand_noise(), rand_noise(),
                                             rand_noise()));
    endtask

    // mostly well-formed clusters, some random words in between
    task automatic queue_random_part(input int count);
        int start_size;
        start_size = pending_cmds.size();
        while (pending_cmds.size() - start_size < count)
        begin
            if ($urandom_range(0, 99) < 80)
                queue_cluster();
            else
                pending_cmds.push_back(random_cmd());
        end
    endtask

    // sender holds off until every word is in and checked
    task automatic wait_quiet();
        while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input int rng, input int frc, input int bst, input int grw,
                             input int bnd, input int frad, input int srad);
        write_reg(REG_RANGE, rng);
        write_reg(REG_FORCE, frc);
        write_reg(REG_BSTEP, bst);
        write_reg(REG_GROW, grw);
        write_reg(REG_BOUND, bnd);
        write_reg(REG_FREE_RAD, frad);
        write_reg(REG_SEED_RAD, srad);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_LOAD;
        particle_index = '0;
        load_x = '0;
        load_y = '0;
        load_z = '0;
        load_vx = '0;
        load_vy = '0;
        load_vz = '0;
        load_attached = 1'b0;
        noise_x = '0;
        noise_y = '0;
        noise_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 14;
        for (int k = 0; k < MAX_PARTICLES; k++)
        begin
            loaded_s[k] = 1'b0;
            attached_s[k] = 1'b0;
            pos_s[k] = '0;
            vel_s[k] = '0;
            rad_s[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the reset register values
        // free particle with nothing attached anywhere
        pending_cmds.push_back(make_load(10, 0, 0, 0, 100, -100, 0, 1'b0));
        pending_cmds.push_back(make_step(10, 49, -50, 0));
        // step of an entry that was never loaded
        pending_cmds.push_back(make_step(200, 3, 3, 3));
        // seed at the origin, then a close free particle that is pulled toward it
        pending_cmds.push_back(make_load(0, 0, 0, 0, 0, 0, 0, 1'b1));
        pending_cmds.push_back(make_load(1, 5000, 0, 0, 0, 0, 0, 1'b0));
        pending_cmds.push_back(make_step(1, 0, 0, 0));
        // another step of the free entry, then a step of the attached seed leaves it alone
        pending_cmds.push_back(make_step(1, 10, 10, 10));
        pending_cmds.push_back(make_step(0, -50, -50, -50));
        // exactly on the seed: zero distance, no pull, still attaches
        pending_cmds.push_back(make_load(2, 0, 0, 0, 0, 0, 0, 1'b0));
        pending_cmds.push_back(make_step(2, 0, 0, 0));
        // in range but outside contact: pull only
        pending_cmds.push_back(make_load(3, 8000, -3000, 2000, 0, 0, 0, 1'b0));
        pending_cmds.push_back(make_step(3, 1, -1, 0));
        // field extremes, wall clamps and saturation
        pending_cmds.push_back(make_load(255, 524287, -524288, 524287,
                                         524287, -524288, -524288, 1'b0));
        pending_cmds.push_back(make_step(255, 49, -50, -50));
        pending_cmds.push_back(make_load(254, -524288, 524287, -524288,
                                         -524288, 524287, 524287, 1'b0));
        pending_cmds.push_back(make_step(254, -50, 49, 49));
        pending_cmds.push_back(make_load(128, 65536, -65536, 0, 0, 0, 0, 1'b1));
        pending_cmds.push_back(make_load(129, 65000, -65000, 0, 900, -900, 0, 1'b0));
        pending_cmds.push_back(make_step(129, 49, -50, 0));
        wait_quiet();

        // defaults, plus a write to an index with no register behind it
        write_reg(REG_NONE, 12345);
        queue_random_part(160);
        wait_quiet();

        // upper extremes of every register
        sender_idle_pct = 52;
        write_all(524287, 65535, 4095, 65535, 262143, 65535, 65535);
        queue_random_part(160);
        wait_quiet();

        // everything at zero: no pull, no kick, walls at the origin
        write_all(0, 0, 0, 0, 0, 0, 0);
        queue_random_part(150);
        wait_quiet();

        // random middle-of-the-road settings, sender never idles
        sender_idle_pct = 0;
        write_all($urandom_range(4000, 40000), $urandom_range(0, 2000),
                  $urandom_range(0, 300), $urandom_range(0, 4000),
                  $urandom_range(40000, 200000), $urandom_range(500, 4000),
                  $urandom_range(1000, 8000));
        queue_random_part(160);
        wait_quiet();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[particle_aggregation_step] OK");
        else
            $display("[particle_aggregation_step] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
